// File: rtl/core/vmr_pkg.sv
`default_nettype none
package vmr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_ENTRIES = 24;

  localparam logic [1:0] OP_ROTATE = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_IDENT  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

  typedef enum logic [1:0] {SEL_PITCH, SEL_YAW, SEL_PD, SEL_RD} angle_sel_t;
  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

  typedef enum logic [1:0] {CD_IDLE, CD_WRAP, CD_RUN, CD_FIN} cordic_state_t;

  typedef enum logic [3:0] {
    CS_IDLE, CS_DISPATCH, CS_YP_SC, CS_YP_MUL, CS_YY_SC, CS_YY_MUL, CS_YP2_MUL,
    CS_PD_SC, CS_PD_MUL, CS_RD_SC, CS_RD_MUL, CS_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       ident;
    logic       sc_start;
    angle_sel_t sc_sel;
    logic       mul_start;
    axis_t      mul_axis;
    logic       mul_pitch;
    logic       mul_negs;
    logic       emit_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic yaw_nz;
    logic pd_nz;
    logic rd_nz;
    logic sc_done;
    logic mul_done;
    logic emit_last;
  } dp_status_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
    logic signed [35:0] v;
    case (idx)
      5'd0:  v = 36'sh03243F6A8;
      5'd1:  v = 36'sh01DAC6705;
      5'd2:  v = 36'sh00FADBAFC;
      5'd3:  v = 36'sh007F56EA6;
      5'd4:  v = 36'sh003FEAB76;
      5'd5:  v = 36'sh001FFD55B;
      5'd6:  v = 36'sh000FFFAAA;
      5'd7:  v = 36'sh0007FFF55;
      5'd8:  v = 36'sh0003FFFEA;
      5'd9:  v = 36'sh0001FFFFD;
      5'd10: v = 36'sh0000FFFFF;
      5'd11: v = 36'sh00007FFFF;
      5'd12: v = 36'sh00003FFFF;
      5'd13: v = 36'sh00001FFFF;
      5'd14: v = 36'sh00000FFFF;
      5'd15: v = 36'sh000007FFF;
      5'd16: v = 36'sh000003FFF;
      5'd17: v = 36'sh000001FFF;
      5'd18: v = 36'sh000000FFF;
      5'd19: v = 36'sh0000007FF;
      5'd20: v = 36'sh0000003FF;
      5'd21: v = 36'sh0000001FF;
      5'd22: v = 36'sh0000000FF;
      5'd23: v = 36'sh00000007F;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/vmr_cordic.sv
`default_nettype none
module vmr_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] angle,
  output logic                    done,
  output logic signed [31:0]      cos_q,
  output logic signed [31:0]      sin_q
);
  import vmr_pkg::*;

  localparam logic signed [33:0] HALF_LSB = 34'sd1 <<< (29 - FRAC_BITS);

  cordic_state_t      state_r, state_nxt;
  logic signed [35:0] z_r;
  logic signed [33:0] x_r, y_r;
  logic signed [33:0] xo, yo, xr, yr;
  logic               neg_r;
  logic [STEP_W-1:0]  i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CD_IDLE: if (start) state_nxt = CD_WRAP;
      CD_WRAP: begin
        if (z_r <= PI_Q30 && z_r >= -PI_Q30) state_nxt = CD_RUN;
      end
      CD_RUN:  if (i_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = CD_FIN;
      CD_FIN:  state_nxt = CD_IDLE;
      default: state_nxt = CD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      CD_IDLE: begin
        // hold the last results until the next start
        if (start) begin
          z_r   <= $signed({{2{angle[15]}}, angle, 18'b0});
          x_r   <= GAIN_Q30;
          y_r   <= '0;
          neg_r <= 1'b0;
          i_r   <= '0;
        end
      end
      CD_WRAP: begin
        // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
        if (z_r > PI_Q30) begin
          z_r <= z_r - TWO_PI_Q30;
        end else if (z_r < -PI_Q30) begin
          z_r <= z_r + TWO_PI_Q30;
        end else if (z_r > HALF_PI_Q30) begin
          z_r   <= z_r - PI_Q30;
          neg_r <= 1'b1;
        end else if (z_r < -HALF_PI_Q30) begin
          z_r   <= z_r + PI_Q30;
          neg_r <= 1'b1;
        end
      end
      CD_RUN: begin
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> i_r);
          y_r <= y_r + (x_r >>> i_r);
          z_r <= z_r - atan_q30(5'(i_r));
        end else begin
          x_r <= x_r + (y_r >>> i_r);
          y_r <= y_r - (x_r >>> i_r);
          z_r <= z_r + atan_q30(5'(i_r));
        end
        i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign xo    = neg_r ? -x_r : x_r;
  assign yo    = neg_r ? -y_r : y_r;
  assign xr    = (xo + HALF_LSB) >>> (30 - FRAC_BITS);
  assign yr    = (yo + HALF_LSB) >>> (30 - FRAC_BITS);
  assign cos_q = xr[31:0];
  assign sin_q = yr[31:0];
  assign done  = (state_r == CD_FIN);

endmodule
`default_nettype wire

// File: rtl/core/vmr_datapath.sv
`default_nettype none
module vmr_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vmr_pkg::ctrl_cmd_t  cmd,
  input  wire logic [3:0]          in_element_index,
  input  wire logic signed [31:0]  in_load_value,
  input  wire logic signed [15:0]  in_yaw_delta,
  input  wire logic signed [15:0]  in_pitch_delta,
  input  wire logic signed [15:0]  in_roll_delta,
  output vmr_pkg::dp_status_t      status,
  output logic [3:0]               out_index,
  output logic signed [31:0]       out_value
);
  import vmr_pkg::*;

  localparam logic signed [65:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] SAT_MAX  = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_MIN  = -66'sh0_8000_0000;

  logic signed [31:0] mat_r [16];
  logic signed [31:0] tmp_r [16];
  logic signed [15:0] yaw_r, pd_r, rd_r, pitch_r;
  logic signed [31:0] pc_r, ps_r;
  angle_sel_t         sel_r;
  logic [3:0]         emit_idx_r;

  logic signed [15:0] sc_angle;
  logic               sc_done;
  logic signed [31:0] sc_cos, sc_sin;

  // product engine
  logic               run_r, pvld_r, copy_r;
  logic [5:0]         cnt_r;
  axis_t              axis_r;
  logic               usep_r, negs_r;
  logic signed [63:0] prod_r;
  logic [1:0]         pk_r;
  logic [3:0]         pidx_r;
  logic signed [65:0] acc_r, sum, rnd;
  logic signed [31:0] rc, rs, rot_v, sat_v;

  logic signed [17:0] p0, p1, p2;

  function automatic logic signed [31:0] rot_elem(input axis_t ax,
      input logic signed [31:0] c, input logic signed [31:0] s, input logic [3:0] ix);
    logic signed [31:0] v;
    v = (ix[3:2] == ix[1:0]) ? ONE_Q : 32'sd0;
    case (ax)
      AX_X: begin
        if (ix == 4'd5 || ix == 4'd10) v = c;
        if (ix == 4'd6) v = -s;
        if (ix == 4'd9) v = s;
      end
      AX_Y: begin
        if (ix == 4'd0 || ix == 4'd10) v = c;
        if (ix == 4'd2) v = s;
        if (ix == 4'd8) v = -s;
      end
      AX_Z: begin
        if (ix == 4'd0 || ix == 4'd5) v = c;
        if (ix == 4'd1) v = s;
        if (ix == 4'd4) v = -s;
      end
      default: ;
    endcase
    return v;
  endfunction

  always_comb begin
    case (cmd.sc_sel)
      SEL_PITCH: sc_angle = pitch_r;
      SEL_YAW:   sc_angle = yaw_r;
      SEL_PD:    sc_angle = pd_r;
      default:   sc_angle = rd_r;
    endcase
  end

  vmr_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sc_start),
    .angle (sc_angle),
    .done  (sc_done),
    .cos_q (sc_cos),
    .sin_q (sc_sin)
  );

  // pitch accumulate with wrap into [-pi, pi]
  always_comb begin
    p0 = 18'(pitch_r) + 18'(pd_r);
    p1 = (p0 > PI_Q12) ? p0 - TWO_PI_Q12 : (p0 < -PI_Q12) ? p0 + TWO_PI_Q12 : p0;
    p2 = (p1 > PI_Q12) ? p1 - TWO_PI_Q12 : (p1 < -PI_Q12) ? p1 + TWO_PI_Q12 : p1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      yaw_r <= in_yaw_delta;
      pd_r  <= in_pitch_delta;
      rd_r  <= in_roll_delta;
    end
    if (cmd.sc_start) sel_r <= cmd.sc_sel;
    if (sc_done && sel_r == SEL_PITCH) begin
      pc_r <= sc_cos;
      ps_r <= sc_sin;
    end
    if (cmd.mul_start) begin
      axis_r <= cmd.mul_axis;
      usep_r <= cmd.mul_pitch;
      negs_r <= cmd.mul_negs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r    <= '0;
      emit_idx_r <= '0;
    end else begin
      if (cmd.ident) pitch_r <= '0;
      else if (cmd.sc_start && cmd.sc_sel == SEL_PD) pitch_r <= p2[15:0];
      if (cmd.capture) emit_idx_r <= '0;
      else if (cmd.emit_adv) emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  // rotation operand for the current product step
  assign rc    = usep_r ? pc_r : sc_cos;
  assign rs    = usep_r ? (negs_r ? -ps_r : ps_r) : sc_sin;
  assign rot_v = rot_elem(axis_r, rc, rs, {cnt_r[1:0], cnt_r[3:2]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pvld_r <= 1'b0;
      copy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cmd.mul_start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'd63) run_r <= 1'b0;
      end
      pvld_r <= run_r;
      copy_r <= pvld_r && pk_r == 2'd3 && pidx_r == 4'd15;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mat_r[{cnt_r[5:4], cnt_r[1:0]}] * rot_v;
    pk_r   <= cnt_r[1:0];
    pidx_r <= cnt_r[5:2];
    if (pvld_r) acc_r <= sum;
  end

  // accumulate four products, round, saturate
  always_comb begin
    sum = ((pk_r == 2'd0) ? 66'sd0 : acc_r) + 66'(prod_r);
    rnd = (sum + RND_HALF) >>> FRAC_BITS;
    if (rnd > SAT_MAX) sat_v = 32'sh7FFF_FFFF;
    else if (rnd < SAT_MIN) sat_v = -32'sh8000_0000;
    else sat_v = rnd[31:0];
  end

  always_ff @(posedge clk) begin
    if (pvld_r && pk_r == 2'd3) tmp_r[pidx_r] <= sat_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ident) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
    end else if (cmd.load) begin
      mat_r[in_element_index] <= in_load_value;
    end else if (copy_r) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= tmp_r[i];
    end
  end

  assign status.yaw_nz    = (yaw_r != 16'sd0);
  assign status.pd_nz     = (pd_r != 16'sd0);
  assign status.rd_nz     = (rd_r != 16'sd0);
  assign status.sc_done   = sc_done;
  assign status.mul_done  = copy_r;
  assign status.emit_last = (emit_idx_r == 4'd15);

  assign out_index = emit_idx_r;
  assign out_value = mat_r[emit_idx_r];

endmodule
`default_nettype wire

// File: rtl/core/vmr_ctrl.sv
`default_nettype none
module vmr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_operation,
  input  wire logic                out_stall,
  input  wire vmr_pkg::dp_status_t status,
  output logic                     in_stall,
  output logic                     out_valid,
  output vmr_pkg::ctrl_cmd_t       cmd
);
  import vmr_pkg::*;

  ctrl_state_t state_r, state_nxt;
  ctrl_state_t after_yaw, after_pd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    after_pd  = status.rd_nz ? CS_RD_SC : CS_EMIT;
    after_yaw = status.pd_nz ? CS_PD_SC : after_pd;
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != CS_IDLE);
    out_valid = (state_r == CS_EMIT);

    case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          cmd.capture = (in_operation == OP_ROTATE);
          cmd.load    = (in_operation == OP_LOAD);
          cmd.ident   = (in_operation == OP_IDENT);
          if (in_operation == OP_ROTATE) state_nxt = CS_DISPATCH;
        end
      end
      CS_DISPATCH: state_nxt = status.yaw_nz ? CS_YP_SC : after_yaw;
      CS_YP_SC:    if (status.sc_done)  state_nxt = CS_YP_MUL;
      CS_YP_MUL:   if (status.mul_done) state_nxt = CS_YY_SC;
      CS_YY_SC:    if (status.sc_done)  state_nxt = CS_YY_MUL;
      CS_YY_MUL:   if (status.mul_done) state_nxt = CS_YP2_MUL;
      CS_YP2_MUL:  if (status.mul_done) state_nxt = after_yaw;
      CS_PD_SC:    if (status.sc_done)  state_nxt = CS_PD_MUL;
      CS_PD_MUL:   if (status.mul_done) state_nxt = after_pd;
      CS_RD_SC:    if (status.sc_done)  state_nxt = CS_RD_MUL;
      CS_RD_MUL:   if (status.mul_done) state_nxt = CS_EMIT;
      CS_EMIT: begin
        if (!out_stall) begin
          cmd.emit_adv = 1'b1;
          if (status.emit_last) state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase

    // launch units on entry into their step
    if (state_nxt != state_r) begin
      case (state_nxt)
        CS_YP_SC: begin cmd.sc_start = 1'b1; cmd.sc_sel = SEL_PITCH; end
        CS_YY_SC: begin cmd.sc_start = 1'b1; cmd.sc_sel = SEL_YAW;   end
        CS_PD_SC: begin cmd.sc_start = 1'b1; cmd.sc_sel = SEL_PD;    end
        CS_RD_SC: begin cmd.sc_start = 1'b1; cmd.sc_sel = SEL_RD;    end
        CS_YP_MUL: begin
          cmd.mul_start = 1'b1; cmd.mul_axis = AX_X;
          cmd.mul_pitch = 1'b1; cmd.mul_negs = 1'b1;
        end
        CS_YY_MUL:  begin cmd.mul_start = 1'b1; cmd.mul_axis = AX_Y; end
        CS_YP2_MUL: begin
          cmd.mul_start = 1'b1; cmd.mul_axis = AX_X; cmd.mul_pitch = 1'b1;
        end
        CS_PD_MUL:  begin cmd.mul_start = 1'b1; cmd.mul_axis = AX_X; end
        CS_RD_MUL:  begin cmd.mul_start = 1'b1; cmd.mul_axis = AX_Z; end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/view_matrix_rotate.sv
`default_nettype none
// Camera view matrix rotator. Holds a 4x4 signed Q16.16 matrix and an
// accumulated pitch angle (Q3.12 radians, kept in [-pi, pi]). A load request
// writes one element, a reset request restores the identity and clears pitch;
// neither produces output. A rotate request applies, in order, the yaw step
// (Rx(-pitch) * Ry(yaw) * Rx(pitch), with the pitch from before the request),
// the pitch step (Rx(delta), pitch accumulated) and the roll step (Rz(delta));
// a zero delta skips its step. Then all sixteen elements stream out in index
// order with last on the final one. Rate: one request is taken at a time.
// A rotate with all three deltas nonzero takes five matrix products and four
// sine/cosine evaluations. Products use the single 32x32 multiply-accumulate
// unit, one product term per cycle, and sines and cosines the iterative CORDIC.
// Elements round half up and saturate to 32 bits.
module view_matrix_rotate (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [3:0]         in_element_index,
  input  wire logic signed [31:0] in_load_value,
  input  wire logic signed [15:0] in_yaw_delta,
  input  wire logic signed [15:0] in_pitch_delta,
  input  wire logic signed [15:0] in_roll_delta,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              out_index,
  output logic signed [31:0]      out_value,
  output logic                    out_last
);
  import vmr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequence the steps of a rotate request
  vmr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_stall    (out_stall),
    .status       (status),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  // matrix storage, pitch, sine/cosine and the product engine
  vmr_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_element_index (in_element_index),
    .in_load_value    (in_load_value),
    .in_yaw_delta     (in_yaw_delta),
    .in_pitch_delta   (in_pitch_delta),
    .in_roll_delta    (in_roll_delta),
    .status           (status),
    .out_index        (out_index),
    .out_value        (out_value)
  );

  // flag the sixteenth element of the stream
  assign out_last = status.emit_last;

endmodule
`default_nettype wire

// File: rtl/core/vmr_checker.sv
`default_nettype none
module vmr_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [3:0]        out_index,
  input wire logic signed [31:0] out_value,
  input wire logic              out_last
);

  // no request taken while elements stream out
  a_stall_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request accepted during output");

  // a stream runs through all sixteen elements in order
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid &&
      out_index == $past(out_index) + 4'd1) else $error("output stream broken");

  // last marks exactly the final index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_index == 4'd15))) else $error("bad last");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(out_value))
    else $error("stalled output changed");

endmodule

bind view_matrix_rotate vmr_checker u_vmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_index (out_index),
  .out_value (out_value),
  .out_last  (out_last)
);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import vmr_pkg::*;

  // Request as it travels on the input channel
  typedef struct {
    logic [1:0]         op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [15:0] yaw;
    logic signed [15:0] pd;
    logic signed [15:0] rd;
  } cam_req_t;

  // One emitted matrix element as the output channel should carry it
  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic               last;
  } elem_t;

  localparam longint PI_12     = 12868;
  localparam longint TWO_PI_12 = 25736;
  localparam longint PI_30     = 64'sd3373259426;
  localparam longint HPI_30    = 64'sd1686629713;
  localparam longint TPI_30    = 64'sd6746518852;
  localparam longint GAIN_30   = 64'sd652032874;
  localparam int     LIMIT     = 3000000;

  localparam longint ARCTAN [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic [3:0]         in_element_index;
  logic signed [31:0] in_load_value;
  logic signed [15:0] in_yaw_delta;
  logic signed [15:0] in_pitch_delta;
  logic signed [15:0] in_roll_delta;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         out_index;
  logic signed [31:0] out_value;
  logic               out_last;

  view_matrix_rotate uut (.*);

  // Predictor state: our own copy of the camera matrix and the pitch angle
  int       cam_mtx [16];
  int       cam_pitch;
  cam_req_t pending_reqs [$];
  elem_t    elems_due [$];
  int       errors;
  int       cycles;
  int       n_rotates;
  int       n_elems;
  bit       req_taken;
  int       gap_left;
  int       burst_left;
  int       stall_mode_left;
  bit       stall_heavy;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic void cam_identity();
    for (int i = 0; i < 16; i++) cam_mtx[i] = (i % 5 == 0) ? (1 << FRAC_BITS) : 0;
    cam_pitch = 0;
  endfunction

  // Rotation-mode CORDIC on a Q3.12 angle, results in Q(FRAC_BITS)
  function automatic void cam_sincos(input longint ang, output int cv, output int sv);
    longint z, x, y, nx, half;
    bit     flip;
    z = ang * 262144;
    x = GAIN_30;
    y = 0;
    flip = 1'b0;
    while (z > PI_30) z -= TPI_30;
    while (z < -PI_30) z += TPI_30;
    if (z > HPI_30) begin
      z -= PI_30;
      flip = 1'b1;
    end else if (z < -HPI_30) begin
      z += PI_30;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    half = longint'(1) << (29 - FRAC_BITS);
    cv = int'((x + half) >>> (30 - FRAC_BITS));
    sv = int'((y + half) >>> (30 - FRAC_BITS));
  endfunction

  // Post-multiply the camera matrix by a rotation about one axis
  function automatic void cam_rotate(input axis_t ax, input int cv, input int sv);
    int     rot [16];
    int     nxt [16];
    longint acc, v;
    for (int i = 0; i < 16; i++) rot[i] = (i % 5 == 0) ? (1 << FRAC_BITS) : 0;
    case (ax)
      AX_X: begin
        rot[5] = cv; rot[6] = -sv; rot[9] = sv; rot[10] = cv;
      end
      AX_Y: begin
        rot[0] = cv; rot[2] = sv; rot[8] = -sv; rot[10] = cv;
      end
      default: begin
        rot[0] = cv; rot[1] = sv; rot[4] = -sv; rot[5] = cv;
      end
    endcase
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc += longint'(cam_mtx[r*4+k]) * longint'(rot[k*4+c]);
        v = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        nxt[r*4+c] = int'(v);
      end
    cam_mtx = nxt;
  endfunction

  // Apply one accepted request and queue the elements it emits
  function automatic void cam_apply(input cam_req_t q);
    int    pc, ps, cv, sv, p;
    elem_t e;
    case (q.op)
      OP_LOAD:  cam_mtx[q.idx] = q.val;
      OP_IDENT: cam_identity();
      OP_ROTATE: begin
        if (q.yaw != 0) begin
          cam_sincos(cam_pitch, pc, ps);
          cam_rotate(AX_X, pc, -ps);
          cam_sincos(q.yaw, cv, sv);
          cam_rotate(AX_Y, cv, sv);
          cam_rotate(AX_X, pc, ps);
        end
        if (q.pd != 0) begin
          p = cam_pitch + int'(q.pd);
          while (p > PI_12) p -= TWO_PI_12;
          while (p < -PI_12) p += TWO_PI_12;
          cam_pitch = p;
          cam_sincos(q.pd, cv, sv);
          cam_rotate(AX_X, cv, sv);
        end
        if (q.rd != 0) begin
          cam_sincos(q.rd, cv, sv);
          cam_rotate(AX_Z, cv, sv);
        end
        for (int i = 0; i < 16; i++) begin
          e.idx = 4'(i);
          e.value = cam_mtx[i];
          e.last = (i == 15);
          elems_due.push_back(e);
        end
        n_rotates++;
      end
      default: ;  // unused code: ignored
    endcase
  endfunction

  function automatic cam_req_t mk(input logic [1:0] op, input logic [3:0] idx,
                                  input logic signed [31:0] val, input logic signed [15:0] yaw,
                                  input logic signed [15:0] pd, input logic signed [15:0] rd);
    cam_req_t q;
    q.op = op; q.idx = idx; q.val = val; q.yaw = yaw; q.pd = pd; q.rd = rd;
    return q;
  endfunction

  // Random delta: zero often so that every step gets skipped sometimes
  function automatic logic signed [15:0] rnd_delta();
    case ($urandom_range(0, 5))
      0, 1:    return 16'sd0;
      2:       return 16'($urandom);
      default: return $signed(16'($urandom_range(0, 12000))) - 16'sd6000;
    endcase
  endfunction

  // Sample: record accepted requests into the predictor at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    req_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      cam_apply(mk(in_operation, in_element_index, in_load_value, in_yaw_delta,
                   in_pitch_delta, in_roll_delta));
      req_taken = 1'b1;
    end
  end

  // Monitor: compare every accepted element with the oldest one due
  always @(posedge clk) begin
    elem_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_elems++;
      if (elems_due.size() == 0) begin
        $error("unexpected element index=%0d value=%0d", out_index, out_value);
        errors++;
      end else begin
        e = elems_due.pop_front();
        if (out_index !== e.idx) begin
          $error("out_index expected %0d actual %0d", e.idx, out_index);
          errors++;
        end
        if (out_value !== e.value) begin
          $error("out_value expected %0d actual %0d (index %0d)", e.value, out_value, e.idx);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("out_last expected %0d actual %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  // Driver: change inputs on the falling edge; bursts with random gaps
  always @(negedge clk) begin
    cam_req_t q;
    if (rst_n) begin
      if (in_valid && req_taken) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      end
      if (!in_valid || req_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 6);
          q = pending_reqs.pop_front();
          in_valid         <= 1'b1;
          in_operation     <= q.op;
          in_element_index <= q.idx;
          in_load_value    <= q.val;
          in_yaw_delta     <= q.yaw;
          in_pitch_delta   <= q.pd;
          in_roll_delta    <= q.rd;
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Receiver stall: alternate stretches of free flow and heavy stalling
      if (stall_mode_left == 0) begin
        stall_heavy = $urandom_range(0, 2) == 0;
        stall_mode_left = $urandom_range(10, 80);
      end
      stall_mode_left--;
      out_stall <= stall_heavy ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    errors = 0; cycles = 0; n_rotates = 0; n_elems = 0;
    gap_left = 0; burst_left = 0; stall_mode_left = 0; stall_heavy = 1'b0;
    req_taken = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_ROTATE;
    in_element_index = '0;
    in_load_value = '0;
    in_yaw_delta = '0;
    in_pitch_delta = '0;
    in_roll_delta = '0;
    out_stall = 1'b0;
    cam_identity();

    // Directed: all-zero rotate, each axis alone, extremes, saturation, unused code
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 16'sd3217, 0, 0));
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 0, 16'sd6434, 0));
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 16'sd1000, 0, 0));  // yaw with pitch set
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 0, 0, -16'sd3217));
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 16'sd32767, 16'sd32767, 16'sd32767));
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, -16'sd32768, -16'sd32768, -16'sd32768));
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 16'sd1, -16'sd1, 16'sd1));
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 0, 16'sd12868, 16'sd6434));  // wrap past pi
    pending_reqs.push_back(mk(OP_IDENT, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_LOAD, 4'd0, 32'sh7FFFFFFF, 0, 0, 0));
    pending_reqs.push_back(mk(OP_LOAD, 4'd1, 32'sh7FFFFFFF, 0, 0, 0));
    pending_reqs.push_back(mk(OP_LOAD, 4'd5, -32'sh80000000, 0, 0, 0));
    pending_reqs.push_back(mk(OP_LOAD, 4'd6, -32'sh80000000, 0, 0, 0));
    pending_reqs.push_back(mk(OP_LOAD, 4'd15, 32'sh0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_RSVD, 4'd15, 32'sh12345678, 16'sd5, 16'sd5, 16'sd5));
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 0, 0, 16'sd3217));   // saturate row 0
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 0, 16'sd3217, 0));   // saturate row 1
    pending_reqs.push_back(mk(OP_ROTATE, 0, 0, 16'sd3217, 0, 0));
    pending_reqs.push_back(mk(OP_IDENT, 0, 0, 0, 0, 0));

    // Random: mostly rotates on loaded matrices, with loads, resets and noise
    for (int i = 0; i < 90; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        pending_reqs.push_back(mk(OP_ROTATE, 4'($urandom), $urandom, rnd_delta(),
                                  rnd_delta(), rnd_delta()));
      else if (r < 85)
        pending_reqs.push_back(mk(OP_LOAD, 4'($urandom), $urandom_range(0, 1) ? $urandom :
                                  ($signed(32'($urandom_range(0, 262144))) - 32'sd131072),
                                  16'($urandom), 16'($urandom), 16'($urandom)));
      else if (r < 93)
        pending_reqs.push_back(mk(OP_IDENT, 4'($urandom), $urandom, 16'($urandom),
                                  16'($urandom), 16'($urandom)));
      else
        pending_reqs.push_back(mk(OP_RSVD, 4'($urandom), $urandom, 16'($urandom),
                                  16'($urandom), 16'($urandom)));
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Drain: all requests sent and every element seen
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || elems_due.size() != 0);
    repeat (200) @(posedge clk);
    if (elems_due.size() != 0) begin
      $error("%0d elements never arrived", elems_due.size());
      errors++;
    end

    $display("Covered %0d rotate requests and %0d matrix elements, with loads, resets,",
             n_rotates, n_elems);
    $display("unused opcodes, field extremes, pitch wrap and saturation; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
